// ----- sv/dccpd_pkg.sv -----
// DCC packet deframer package: field widths, phase codes, config indexes
// and the struct types shared by the core and the top level.
// No dependencies.
package dccpd_pkg;

	localparam int RunW     = 5;
	localparam int SlotW    = 3;
	localparam int ByteW    = 8;
	localparam int CountW   = 2;
	localparam int CfgIdxW  = 4;
	localparam int CfgDataW = 8;

	localparam logic [CountW-1:0] StoreDepth = 2'd3;
	localparam logic [RunW-1:0]   RunMax     = 5'd31;
	localparam logic [SlotW-1:0]  LastSlot   = 3'd7;

	// receive phases
	localparam logic [1:0] PhPreamble = 2'd0;
	localparam logic [1:0] PhLead     = 2'd1;
	localparam logic [1:0] PhByte     = 2'd2;
	localparam logic [1:0] PhTrailer  = 2'd3;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] RegPreambleMin = 4'd0;
	localparam logic [CfgIdxW-1:0] RegInvertLine  = 4'd1;

	localparam logic [RunW-1:0] PreambleMinRst = 5'd10;
	localparam logic            InvertLineRst  = 1'b1;

	typedef struct packed {
		logic [RunW-1:0] preamble_min;
		logic            invert_line;
	} cfg_t;

	typedef struct packed {
		logic [ByteW-1:0]  first_byte;
		logic [ByteW-1:0]  second_byte;
		logic [ByteW-1:0]  third_byte;
		logic [CountW-1:0] received_count;
		logic              too_long;
	} pkt_t;

endpackage

// ----- sv/dccpd_if.sv -----
// Channel interfaces of the DCC packet deframer: sample input, packet
// output and configuration write. Depends on dccpd_pkg.

interface dccpd_sample_if;
	logic valid;
	logic ready;
	logic line_level;

	modport source (output valid, output line_level, input ready);
	modport sink (input valid, input line_level, output ready);
endinterface

interface dccpd_packet_if import dccpd_pkg::*;;
	logic              valid;
	logic              ready;
	logic [ByteW-1:0]  first_byte;
	logic [ByteW-1:0]  second_byte;
	logic [ByteW-1:0]  third_byte;
	logic [CountW-1:0] received_count;
	logic              too_long;

	modport source (output valid, output first_byte, output second_byte, output third_byte,
		output received_count, output too_long, input ready);
	modport sink (input valid, input first_byte, input second_byte, input third_byte,
		input received_count, input too_long, output ready);
endinterface

interface dccpd_cfg_if import dccpd_pkg::*;;
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/dccpd_core.sv -----
// Bit-level receive state machine: preamble count, byte assembly and the
// three-byte packet store. Depends on dccpd_pkg.
module dccpd_core import dccpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic bit_in,
	input  cfg_t cfg,
	output logic res_hit,
	output pkt_t res
);

	logic [1:0]        phase_q;
	logic [RunW-1:0]   run_q;
	logic [SlotW-1:0]  slot_q;
	logic [CountW-1:0] count_q;
	logic [ByteW-1:0]  store_q [3];
	logic              ovf_q;

	logic [RunW-1:0]  run_inc;
	logic [ByteW-1:0] bit_mask;
	logic             room;

	assign run_inc  = (run_q < RunMax) ? run_q + 1'b1 : run_q;
	assign bit_mask = {bit_in, {(ByteW-1){1'b0}}} >> slot_q;
	assign room     = count_q < StoreDepth;

	// store is stable in the trailer phase, so the packet reads it directly
	assign res_hit = (phase_q == PhTrailer) && bit_in;
	assign res.first_byte     = store_q[0];
	assign res.second_byte    = store_q[1];
	assign res.third_byte     = store_q[2];
	assign res.received_count = count_q;
	assign res.too_long       = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PhPreamble;
			run_q      <= '0;
			slot_q     <= '0;
			count_q    <= '0;
			ovf_q      <= 1'b0;
			store_q[0] <= '0;
			store_q[1] <= '0;
			store_q[2] <= '0;
		end else if (step) begin
			case (phase_q)
				PhPreamble: begin
					if (bit_in) begin
						run_q <= run_inc;
						if (run_inc >= cfg.preamble_min) phase_q <= PhLead;
					end else begin
						run_q <= '0;
					end
				end
				PhLead: begin
					if (bit_in) begin
						run_q <= run_inc;
					end else begin
						// packet start: clear the store
						store_q[0] <= '0;
						store_q[1] <= '0;
						store_q[2] <= '0;
						count_q    <= '0;
						ovf_q      <= 1'b0;
						slot_q     <= '0;
						phase_q    <= PhByte;
					end
				end
				PhByte: begin
					if (room) begin
						case (count_q)
							2'd0:    store_q[0] <= store_q[0] | bit_mask;
							2'd1:    store_q[1] <= store_q[1] | bit_mask;
							default: store_q[2] <= store_q[2] | bit_mask;
						endcase
					end
					if (slot_q == LastSlot) begin
						slot_q  <= '0;
						phase_q <= PhTrailer;
						if (room) count_q <= count_q + 1'b1;
						else ovf_q <= 1'b1;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				default: begin
					if (!bit_in) begin
						phase_q <= PhByte;
					end else begin
						run_q   <= '0;
						slot_q  <= '0;
						phase_q <= PhPreamble;
					end
				end
			endcase
		end
	end

endmodule

// ----- sv/dcc_packet_deframer.sv -----
// Channel   | Dir | Beat
// ----------+-----+-----------------------------------------------------
// sample    | in  | one line level per tick
// packet    | out | three bytes, byte count, overflow flag per packet end
// cfg       | in  | register index and write data, always ready
//
// One sample per clock unless stalled: a sample is registered, then decoded
// by the core and, on a packet end bit, lands in the output register.
// Packet valid rises when the output register loads that end-bit packet.
// A held packet stalls only samples that end another packet behind it.
// Reset clears all control state and the store; config returns to defaults.
//
// Top level of the DCC packet deframer. Depends on dccpd_pkg, dccpd_if and
// dccpd_core.
module dcc_packet_deframer import dccpd_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	dccpd_sample_if.sink   sample,
	dccpd_packet_if.source packet,
	dccpd_cfg_if.sink      cfg
);

	cfg_t cfg_q;
	logic valid_s1;
	logic level_s1;
	logic out_valid_q;
	pkt_t out_q;

	logic bit_s1;
	logic res_hit;
	pkt_t res;
	logic advance_s1;
	logic out_free;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.preamble_min <= PreambleMinRst;
			cfg_q.invert_line  <= InvertLineRst;
		end else if (cfg.valid) begin
			case (cfg.index)
				RegPreambleMin: cfg_q.preamble_min <= cfg.data[RunW-1:0];
				RegInvertLine:  cfg_q.invert_line  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign bit_s1     = level_s1 ^ cfg_q.invert_line;
	assign out_free   = !out_valid_q || packet.ready;
	assign advance_s1 = valid_s1 && (!res_hit || out_free);
	assign sample.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) level_s1 <= sample.line_level;
	end

	dccpd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance_s1),
		.bit_in  (bit_s1),
		.cfg     (cfg_q),
		.res_hit (res_hit),
		.res     (res)
	);

	// load a new packet or drop the one just taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && res_hit) begin
			out_valid_q <= 1'b1;
		end else if (packet.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && res_hit) out_q <= res;
	end

	assign packet.valid          = out_valid_q;
	assign packet.first_byte     = out_q.first_byte;
	assign packet.second_byte    = out_q.second_byte;
	assign packet.third_byte     = out_q.third_byte;
	assign packet.received_count = out_q.received_count;
	assign packet.too_long       = out_q.too_long;

`ifndef SYNTHESIS
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		packet.valid |-> packet.received_count != '0)
		else $error("packet with zero byte count");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		packet.valid && packet.too_long |-> packet.received_count == StoreDepth)
		else $error("overflow flagged on a short packet");

	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> valid_s1 && res_hit && out_valid_q)
		else $error("sample stalled without a blocked packet");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !packet.ready |=> $stable(out_q))
		else $error("held packet overwritten");
`endif

endmodule
